// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ATCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ATCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ATCP_ASSERT(lbl, clk, rst_n, prop, msg)

`define ATCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/atcp_pkg.sv =====
// shared constants, types and helpers of the at command line parser
// no dependencies
package atcp_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;

    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_PLS = 8'h2B;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam int PREFIX_LEN = 3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PREFIX   = 3'd1,
        ST_NOEQ     = 3'd2,
        ST_NOFUNC   = 3'd3,
        ST_NOPARAM  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t    status;
        logic       part;
        logic [7:0] char_out;
        logic       last;
    } result_t;

    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_A;
            2'd1:    ch = CH_T;
            default: ch = CH_PLS;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/atcp_line_ram.sv =====
// line buffer memory, one write port and one registered read port
// depends on atcp_pkg
module atcp_line_ram (
    input  logic                    clk,
    input  atcp_pkg::ram_req_t      req,
    output logic [7:0]              rdata
);

    logic [7:0] mem [atcp_pkg::BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/atcp_ctrl.sv =====
// line collection, line check and readout sequencer
// depends on atcp_pkg; drives atcp_line_ram and atcp_out_reg
module atcp_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    output atcp_pkg::ram_req_t                ram_req,
    input  logic [7:0]                        ram_rdata,
    input  logic                              out_free,
    output logic                              res_load,
    output atcp_pkg::result_t                 res
);

    localparam int AW = atcp_pkg::ADDR_W;
    localparam int CW = atcp_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TERM = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       eq_pos_reg, eq_pos_next;
    logic                eq_seen_reg, eq_seen_next;
    logic                ovf_reg, ovf_next;
    logic                pfx_bad_reg, pfx_bad_next;
    atcp_pkg::status_t   st_reg, st_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                part_reg, part_next;

    logic                accept;
    logic                room;
    logic                is_last;
    atcp_pkg::status_t   check_st;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign room     = fill_reg < CW'(atcp_pkg::BUF_DEPTH - 1);
    assign is_last  = part_reg && (({1'b0, idx_reg} + CW'(1)) == fill_reg);

    always_comb
    begin
        if (ovf_reg)
            check_st = atcp_pkg::ST_OVERFLOW;
        else if (fill_reg < CW'(atcp_pkg::PREFIX_LEN) || pfx_bad_reg)
            check_st = atcp_pkg::ST_PREFIX;
        else if (!eq_seen_reg)
            check_st = atcp_pkg::ST_NOEQ;
        else if (eq_pos_reg == AW'(atcp_pkg::PREFIX_LEN))
            check_st = atcp_pkg::ST_NOFUNC;
        else if (({1'b0, eq_pos_reg} + CW'(1)) >= fill_reg)
            check_st = atcp_pkg::ST_NOPARAM;
        else
            check_st = atcp_pkg::ST_OK;
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        eq_pos_next   = eq_pos_reg;
        eq_seen_next  = eq_seen_reg;
        ovf_next      = ovf_reg;
        pfx_bad_next  = pfx_bad_reg;
        st_next       = st_reg;
        idx_next      = idx_reg;
        part_next     = part_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = fill_reg[AW-1:0];
        ram_req.wdata = rx_byte;
        ram_req.re    = 1'b0;
        ram_req.raddr = idx_reg;
        res_load      = 1'b0;
        res.status    = atcp_pkg::ST_OK;
        res.part      = part_reg;
        res.char_out  = ram_rdata;
        res.last      = is_last;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rx_byte == atcp_pkg::CH_DOT)
                    begin
                        st_next    = check_st;
                        state_next = S_TERM;
                    end
                    else if (room)
                    begin
                        ram_req.we = 1'b1;
                        fill_next  = fill_reg + CW'(1);
                        if (fill_reg < CW'(atcp_pkg::PREFIX_LEN) &&
                            rx_byte != atcp_pkg::prefix_char(fill_reg[1:0]))
                        begin
                            pfx_bad_next = 1'b1;
                        end
                        if (rx_byte == atcp_pkg::CH_EQ && !eq_seen_reg &&
                            fill_reg >= CW'(atcp_pkg::PREFIX_LEN))
                        begin
                            eq_seen_next = 1'b1;
                            eq_pos_next  = fill_reg[AW-1:0];
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_TERM:
            begin
                if (st_reg != atcp_pkg::ST_OK)
                begin
                    if (out_free)
                    begin
                        res_load     = 1'b1;
                        res.status   = st_reg;
                        res.part     = 1'b0;
                        res.char_out = 8'd0;
                        res.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = AW'(atcp_pkg::PREFIX_LEN);
                    part_next  = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_req.re = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (!part_reg && (idx_reg + AW'(1)) == eq_pos_reg)
                        begin
                            idx_next  = eq_pos_reg + AW'(1);
                            part_next = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + AW'(1);
                        end
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // line state clears once the line's final result is loaded
        if (res_load && res.last)
        begin
            fill_next    = '0;
            eq_pos_next  = '0;
            eq_seen_next = 1'b0;
            ovf_next     = 1'b0;
            pfx_bad_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            eq_pos_reg  <= '0;
            eq_seen_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            pfx_bad_reg <= 1'b0;
            st_reg      <= atcp_pkg::ST_OK;
            idx_reg     <= '0;
            part_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            eq_pos_reg  <= eq_pos_next;
            eq_seen_reg <= eq_seen_next;
            ovf_reg     <= ovf_next;
            pfx_bad_reg <= pfx_bad_next;
            st_reg      <= st_next;
            idx_reg     <= idx_next;
            part_reg    <= part_next;
        end
    end

endmodule

// ===== sv/atcp_out_reg.sv =====
// output register holding one result transaction until it is taken
// depends on atcp_pkg
module atcp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_load,
    input  atcp_pkg::result_t   res,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic                part,
    output logic [7:0]          char_out,
    output logic                last
);

    logic               valid_reg;
    atcp_pkg::result_t  res_reg;

    assign out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign status    = res_reg.status;
    assign part      = res_reg.part;
    assign char_out  = res_reg.char_out;
    assign last      = res_reg.last;

endmodule

// ===== sv/at_command_line_parser_top.sv =====
// AT command line parser: an ordinary byte is taken and written to the line memory while
// there is room. A '.' on a bad line gives one error transaction, and on a good line each
// extracted byte passes through a read state and a load state, since the readout walks
// the stored line through the single registered read port of the line memory. Input is
// stalled during the readout; output stalls stretch it. No clearing pass after reset.
// depends on atcp_pkg, atcp_line_ram, atcp_ctrl, atcp_out_reg and assert_macros.svh
`include "assert_macros.svh"

module at_command_line_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        part,
    output logic [7:0]  char_out,
    output logic        last
);

    atcp_pkg::ram_req_t ram_req;
    logic [7:0]         ram_rdata;
    logic               out_free;
    logic               res_load;
    atcp_pkg::result_t  res;

    atcp_line_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    atcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res)
    );

    atcp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .part      (part),
        .char_out  (char_out),
        .last      (last)
    );

    `ATCP_ASSERT_IMP(a_err_fields, clk, rst_n, out_valid && status != atcp_pkg::ST_OK, char_out == 8'd0 && part == 1'b0 && last, "error result fields not cleared")
    `ATCP_ASSERT_IMP(a_load_free, clk, rst_n, res_load, out_free, "result loaded over a pending transaction")
    `ATCP_ASSERT_IMP(a_mid_line_stall, clk, rst_n, out_valid && !last, in_stall, "input taken during line readout")

endmodule

// ===== test/tb_at_command_line_parser_top.sv =====
// testbench for at_command_line_parser_top: feeds command lines byte by byte and
// checks every result transaction against a line predictor kept in the bench
// depends on atcp_pkg and the at_command_line_parser_top rtl
`timescale 1ns / 1ps

module tb_at_command_line_parser_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int RX_TARGET   = 380;

    typedef struct {
        logic [7:0] ch;
        int         gap_pct;
        int         stall_pct;
        bit         drain;
    } rx_txn_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    logic       part;
    logic [7:0] char_out;
    logic       last;

    rx_txn_t             rx_backlog[$];
    atcp_pkg::result_t   expected_tokens[$];
    int                  stall_pct = 0;

    // line predictor state
    logic [7:0] line_buf[atcp_pkg::BUF_DEPTH];
    int         line_fill = 0;
    int         eq_index = 0;
    bit         eq_found = 1'b0;
    bit         line_over = 1'b0;

    int         cur_gap = 0;
    int         cur_stall = 0;
    bit         drain_pending = 1'b0;
    int         mismatch_cnt = 0;
    int         bytes_taken = 0;
    int         tokens_checked = 0;
    int         verdict_cnt[6];

    at_command_line_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .part      (part),
        .char_out  (char_out),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void push_token(input atcp_pkg::status_t st, input logic pt,
                                       input logic [7:0] ch, input logic lst);
        atcp_pkg::result_t tok;
        tok.status   = st;
        tok.part     = pt;
        tok.char_out = ch;
        tok.last     = lst;
        expected_tokens.push_back(tok);
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] ch);
        atcp_pkg::status_t verdict;
        if (ch != atcp_pkg::CH_DOT)
        begin
            if (line_fill < atcp_pkg::BUF_DEPTH - 1)
            begin
                if (ch == atcp_pkg::CH_EQ && !eq_found && line_fill >= atcp_pkg::PREFIX_LEN)
                begin
                    eq_found = 1'b1;
                    eq_index = line_fill;
                end
                line_buf[line_fill] = ch;
                line_fill++;
            end
            else
                line_over = 1'b1;
            return;
        end
        if (line_over)
            verdict = atcp_pkg::ST_OVERFLOW;
        else if (line_fill < atcp_pkg::PREFIX_LEN || line_buf[0] != atcp_pkg::CH_A ||
                 line_buf[1] != atcp_pkg::CH_T || line_buf[2] != atcp_pkg::CH_PLS)
            verdict = atcp_pkg::ST_PREFIX;
        else if (!eq_found)
            verdict = atcp_pkg::ST_NOEQ;
        else if (eq_index == atcp_pkg::PREFIX_LEN)
            verdict = atcp_pkg::ST_NOFUNC;
        else if (eq_index + 1 >= line_fill)
            verdict = atcp_pkg::ST_NOPARAM;
        else
            verdict = atcp_pkg::ST_OK;
        verdict_cnt[int'(verdict)]++;
        if (verdict != atcp_pkg::ST_OK)
            push_token(verdict, 1'b0, 8'h00, 1'b1);
        else
        begin
            for (int i = atcp_pkg::PREFIX_LEN; i < eq_index; i++)
                push_token(atcp_pkg::ST_OK, 1'b0, line_buf[i], 1'b0);
            for (int i = eq_index + 1; i < line_fill; i++)
                push_token(atcp_pkg::ST_OK, 1'b1, line_buf[i], logic'(i == line_fill - 1));
        end
        line_fill = 0;
        eq_index  = 0;
        eq_found  = 1'b0;
        line_over = 1'b0;
    endfunction

    function automatic void check_token();
        atcp_pkg::result_t want;
        if (expected_tokens.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result status %0d part %0d char %02h last %0d",
                                    status, part, char_out, last));
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (status != want.status || part != want.part || char_out != want.char_out ||
            last != want.last)
            note_mismatch($sformatf({"expected status %0d part %0d char %02h last %0d, ",
                                     "got status %0d part %0d char %02h last %0d"},
                                    want.status, want.part, want.char_out, want.last,
                                    status, part, char_out, last));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        rx_txn_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else if (!in_valid || !in_stall)
        begin
            if (rx_backlog.size() != 0 && rx_backlog[0].drain &&
                (in_valid || expected_tokens.size() != 0))
                in_valid <= 1'b0;
            else if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= rx_backlog[0].gap_pct)
            begin
                nxt = rx_backlog.pop_front();
                in_valid  <= 1'b1;
                rx_byte   <= nxt.ch;
                stall_pct <= nxt.stall_pct;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                bytes_taken++;
                absorb_rx_byte(rx_byte);
            end
            if (out_valid && !out_stall)
                check_token();
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void push_rx(input logic [7:0] ch);
        rx_txn_t t;
        t.ch        = ch;
        t.gap_pct   = cur_gap;
        t.stall_pct = cur_stall;
        t.drain     = drain_pending;
        drain_pending = 1'b0;
        rx_backlog.push_back(t);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_rx(s[i]);
    endfunction

    function automatic logic [7:0] pick_char(input bit allow_eq);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == atcp_pkg::CH_DOT || (!allow_eq && c == atcp_pkg::CH_EQ));
        return c;
    endfunction

    function automatic void push_chars(input int n, input bit allow_eq);
        for (int i = 0; i < n; i++)
            push_rx(pick_char(allow_eq));
    endfunction

    function automatic void add_random_line(input int line_no);
        int kind;
        int variant;
        int pos;
        logic [7:0] head[3];
        case ((line_no / 5) % 4)
            0: begin cur_gap = 0;  cur_stall = 0;  end
            1: begin cur_gap = 81; cur_stall = 0;  end
            2: begin cur_gap = 0;  cur_stall = 81; end
            default: begin cur_gap = 18; cur_stall = 18; end
        endcase
        if (line_no % 8 == 0)
            drain_pending = 1'b1;
        if (line_no == 12)
        begin
            // longest line that still fits
            push_text("AT+");
            push_chars(1, 1'b0);
            push_rx(atcp_pkg::CH_EQ);
            push_chars(atcp_pkg::BUF_DEPTH - 1 - 5, 1'b1);
            push_rx(atcp_pkg::CH_DOT);
            return;
        end
        if (line_no == 18)
        begin
            // overflow wins over a broken prefix
            push_chars(atcp_pkg::BUF_DEPTH + 2, 1'b1);
            push_rx(atcp_pkg::CH_DOT);
            return;
        end
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            push_text("AT+");
            push_chars($urandom_range(1, 6), 1'b0);
            push_rx(atcp_pkg::CH_EQ);
            push_chars($urandom_range(1, 8), 1'b1);
        end
        else if (kind < 85)
        begin
            variant = $urandom_range(0, 5);
            case (variant)
                0:
                begin
                    push_text("AT+=");
                    push_chars($urandom_range(1, 5), 1'b1);
                end
                1:
                begin
                    push_text("AT+");
                    push_chars($urandom_range(1, 5), 1'b0);
                    push_rx(atcp_pkg::CH_EQ);
                end
                2:
                begin
                    push_text("AT+");
                    push_chars($urandom_range(0, 6), 1'b0);
                end
                3:
                begin
                    head[0] = atcp_pkg::CH_A;
                    head[1] = atcp_pkg::CH_T;
                    head[2] = atcp_pkg::CH_PLS;
                    pos = $urandom_range(0, 2);
                    head[pos] = pick_char(1'b1);
                    while (head[pos] == atcp_pkg::prefix_char(2'(pos)))
                        head[pos] = pick_char(1'b1);
                    for (int i = 0; i < 3; i++)
                        push_rx(head[i]);
                    push_chars($urandom_range(1, 4), 1'b0);
                    push_rx(atcp_pkg::CH_EQ);
                    push_chars($urandom_range(1, 4), 1'b1);
                end
                4:
                begin
                    pos = $urandom_range(0, 3);
                    if (pos > 0) push_rx(atcp_pkg::CH_A);
                    if (pos > 1) push_rx(atcp_pkg::CH_T);
                    if (pos > 2) push_rx(atcp_pkg::CH_PLS);
                end
                default:
                begin
                    // equals inside the prefix is not the split point
                    push_rx(atcp_pkg::CH_A);
                    push_rx($urandom_range(0, 1) ? atcp_pkg::CH_EQ : atcp_pkg::CH_T);
                    push_rx(atcp_pkg::CH_EQ);
                    push_chars($urandom_range(1, 4), 1'b0);
                    push_rx(atcp_pkg::CH_EQ);
                    push_chars($urandom_range(1, 4), 1'b1);
                end
            endcase
        end
        else
        begin
            for (int i = $urandom_range(0, 12); i > 0; i--)
                push_rx(8'($urandom_range(0, 255)));
        end
        push_rx(atcp_pkg::CH_DOT);
    endfunction

    initial
    begin
        int line_no;
        int cycle_cnt;
        foreach (verdict_cnt[i])
            verdict_cnt[i] = 0;

        // directed lines
        push_text(".");
        push_text("AT+=5.");
        push_text("AT+F=.");
        push_text("AT+X.");
        push_text("AT+");
        push_rx(8'hFF);
        push_rx(atcp_pkg::CH_EQ);
        push_rx(8'h00);
        push_rx(atcp_pkg::CH_DOT);

        line_no = 0;
        while (rx_backlog.size() < RX_TARGET)
        begin
            add_random_line(line_no);
            line_no++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        cycle_cnt = 0;
        while ((rx_backlog.size() != 0 || in_valid || expected_tokens.size() != 0) &&
               cycle_cnt < CYCLE_LIMIT)
        begin
            @(negedge clk);
            cycle_cnt++;
        end

        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
                     expected_tokens.size());
            $display("Testbench completed WITH ERRORS");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            $display("sent %0d bytes: ok %0d, bad prefix %0d, no equals %0d, empty function %0d,",
                     bytes_taken, verdict_cnt[0], verdict_cnt[1], verdict_cnt[2],
                     verdict_cnt[3]);
            $display("empty parameter %0d, overflow %0d lines; %0d results checked, %0d bad",
                     verdict_cnt[4], verdict_cnt[5], tokens_checked, mismatch_cnt);
            if (mismatch_cnt == 0 && expected_tokens.size() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/atcp_pkg.sv
sv/atcp_line_ram.sv
sv/atcp_ctrl.sv
sv/atcp_out_reg.sv
sv/at_command_line_parser_top.sv
test/tb_at_command_line_parser_top.sv
